[rtl/fcme_pkg.sv]
// ----------------------------------------------------------------------------
// fcme_pkg
// Shared types and constants of the mirrored-edge FIR convolution block.
// ----------------------------------------------------------------------------
package fcme_pkg;

    localparam int MAX_TAPS_DEFAULT   = 63;
    localparam int RING_DEPTH_DEFAULT = 128;

    // Widths that cover the largest legal kernel and ring in the job record.
    localparam int JOB_TC_W    = 8;
    localparam int JOB_PTR_W   = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic REQ_TAP    = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] value;
        logic               last;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               last_res;
        logic               short_signal;
    } res_item_t;

    // One output position to compute: position, signal length so far, ring
    // slot of the newest sample, kernel length and the flags of the result.
    typedef struct packed {
        logic [31:0]          pos;
        logic [31:0]          count;
        logic [JOB_PTR_W-1:0] last_ptr;
        logic [JOB_TC_W-1:0]  ntaps;
        logic                 short_flag;
        logic                 last_flag;
    } job_t;

    typedef enum logic {
        FR_IDLE,
        FR_FLUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_ADDR,
        BK_MAC,
        BK_DRAIN,
        BK_SCALE,
        BK_DONE
    } back_state_t;

endpackage

[rtl/fcme_ram.sv]
// ----------------------------------------------------------------------------
// fcme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[rtl/fcme_queue.sv]
// ----------------------------------------------------------------------------
// fcme_queue
// Short job queue between the classifying front and the computing back.
// ----------------------------------------------------------------------------
module fcme_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fcme_pkg::job_t push_job,
    input  logic           pop,
    output fcme_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);
    import fcme_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    job_t           slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] head_reg;
    logic [QAW-1:0] tail_reg;
    logic [QCW-1:0] count_reg;
    logic [QAW-1:0] head_next;
    logic [QAW-1:0] tail_next;
    logic [QCW-1:0] count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QCW'(QUEUE_DEPTH));
    assign head_job = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue read while empty");
`endif

endmodule

[rtl/fcme_front.sv]
// ----------------------------------------------------------------------------
// fcme_front
// Accepts tap and sample items, keeps the kernel and signal counters, writes
// the tap and sample stores and queues one job per output position.
// ----------------------------------------------------------------------------
module fcme_front #(
    parameter int MAX_TAPS   = fcme_pkg::MAX_TAPS_DEFAULT,
    parameter int RING_DEPTH = fcme_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             req_valid,
    output logic                                             req_stall,
    input  fcme_pkg::req_item_t                              req_data,
    input  logic                                             back_idle,
    input  logic                                             q_empty,
    input  logic                                             q_full,
    output logic                                             push,
    output fcme_pkg::job_t                                   push_job,
    output logic                                             tap_we,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] tap_waddr,
    output logic [31:0]                                      tap_wdata,
    output logic                                             ring_we,
    output logic [$clog2(RING_DEPTH)-1:0]                    ring_waddr,
    output logic [31:0]                                      ring_wdata
);
    import fcme_pkg::*;

    localparam int TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TCW = $clog2(MAX_TAPS + 1);
    localparam int RW  = $clog2(RING_DEPTH);

    front_state_t   state_reg;
    front_state_t   state_next;
    logic [TCW-1:0] tap_count_reg;
    logic [TCW-1:0] tap_count_next;
    logic           closed_reg;
    logic           closed_next;
    logic [31:0]    seen_reg;
    logic [31:0]    seen_next;
    logic [31:0]    sent_reg;
    logic [31:0]    sent_next;
    logic [RW-1:0]  wptr_reg;
    logic [RW-1:0]  wptr_next;
    logic [31:0]    fl_pos_reg;
    logic [31:0]    fl_pos_next;
    logic [31:0]    fl_count_reg;
    logic [31:0]    fl_count_next;
    logic [RW-1:0]  fl_ptr_reg;
    logic [RW-1:0]  fl_ptr_next;
    logic           fl_short_reg;
    logic           fl_short_next;

    logic           accept;
    logic           is_sample;
    logic [31:0]    n_new;
    logic           ends_signal;
    logic [TCW-1:0] half;
    logic [TCW-1:0] tc_base;
    logic           fl_final;

    assign accept      = req_valid && !req_stall;
    assign is_sample   = (req_data.req_type == REQ_SAMPLE);
    assign n_new       = seen_reg + 32'd1;
    // A sample that fills the counter to its top closes the signal as well.
    assign ends_signal = req_data.last || (n_new == 32'hFFFF_FFFF);
    assign half        = tap_count_reg >> 1;
    assign tc_base     = closed_reg ? '0 : tap_count_reg;
    assign fl_final    = (fl_pos_reg == fl_count_reg - 32'd1);

    // Items enter only when every earlier job is finished, so the stores
    // never change under a computation in flight.
    always_comb
    begin
        req_stall = 1'b1;
        case (state_reg)
            FR_IDLE:  req_stall = !(q_empty && back_idle);
            FR_FLUSH: req_stall = 1'b1;
            default:  req_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept && is_sample && ends_signal)
                begin
                    state_next = FR_FLUSH;
                end
            end
            FR_FLUSH:
            begin
                if (!q_full && fl_final)
                begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb
    begin
        tap_count_next = tap_count_reg;
        closed_next    = closed_reg;
        seen_next      = seen_reg;
        sent_next      = sent_reg;
        wptr_next      = wptr_reg;
        fl_pos_next    = fl_pos_reg;
        fl_count_next  = fl_count_reg;
        fl_ptr_next    = fl_ptr_reg;
        fl_short_next  = fl_short_reg;
        push           = 1'b0;
        push_job       = '0;
        tap_we         = 1'b0;
        tap_waddr      = tc_base[TAW-1:0];
        tap_wdata      = req_data.value;
        ring_we        = 1'b0;
        ring_waddr     = wptr_reg;
        ring_wdata     = req_data.value;
        case (state_reg)
            FR_IDLE:
            begin
                if (accept && !is_sample)
                begin
                    // A tap abandons any signal in progress.
                    seen_next   = '0;
                    sent_next   = '0;
                    wptr_next   = '0;
                    closed_next = req_data.last;
                    if (tc_base < TCW'(MAX_TAPS))
                    begin
                        tap_we         = 1'b1;
                        tap_count_next = tc_base + 1'b1;
                    end
                    else
                    begin
                        tap_count_next = tc_base;
                    end
                end
                else if (accept)
                begin
                    closed_next = 1'b1;
                    ring_we     = 1'b1;
                    if (ends_signal)
                    begin
                        fl_pos_next   = sent_reg;
                        fl_count_next = n_new;
                        fl_ptr_next   = wptr_reg;
                        fl_short_next = (n_new <= 32'(half));
                        seen_next     = '0;
                        sent_next     = '0;
                        wptr_next     = '0;
                    end
                    else
                    begin
                        seen_next = n_new;
                        wptr_next = (wptr_reg == RW'(RING_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                        if (({1'b0, sent_reg} + 33'(half)) < {1'b0, n_new})
                        begin
                            push                = 1'b1;
                            push_job.pos        = sent_reg;
                            push_job.count      = n_new;
                            push_job.last_ptr   = JOB_PTR_W'(wptr_reg);
                            push_job.ntaps      = JOB_TC_W'(tap_count_reg);
                            push_job.short_flag = 1'b0;
                            push_job.last_flag  = 1'b0;
                            sent_next           = sent_reg + 32'd1;
                        end
                    end
                end
            end
            FR_FLUSH:
            begin
                if (!q_full)
                begin
                    push                = 1'b1;
                    push_job.pos        = fl_pos_reg;
                    push_job.count      = fl_count_reg;
                    push_job.last_ptr   = JOB_PTR_W'(fl_ptr_reg);
                    push_job.ntaps      = JOB_TC_W'(tap_count_reg);
                    push_job.short_flag = fl_short_reg;
                    push_job.last_flag  = fl_final;
                    fl_pos_next         = fl_pos_reg + 32'd1;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FR_IDLE;
            tap_count_reg <= '0;
            closed_reg    <= 1'b0;
            seen_reg      <= '0;
            sent_reg      <= '0;
            wptr_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_count_reg <= tap_count_next;
            closed_reg    <= closed_next;
            seen_reg      <= seen_next;
            sent_reg      <= sent_next;
            wptr_reg      <= wptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fl_pos_reg   <= fl_pos_next;
        fl_count_reg <= fl_count_next;
        fl_ptr_reg   <= fl_ptr_next;
        fl_short_reg <= fl_short_next;
    end

`ifndef SYNTHESIS
    a_flush_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FR_FLUSH) |-> (!tap_we && !ring_we))
        else $error("store written during a flush");
`endif

endmodule

[rtl/fcme_back.sv]
// ----------------------------------------------------------------------------
// fcme_back
// Takes one job at a time, walks the kernel (not for a short signal or an
// empty kernel) through a pipelined multiply-accumulate with mirrored
// sample addressing, and rounds and saturates the sum into the output register.
// ----------------------------------------------------------------------------
module fcme_back #(
    parameter int MAX_TAPS   = fcme_pkg::MAX_TAPS_DEFAULT,
    parameter int RING_DEPTH = fcme_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             q_empty,
    input  fcme_pkg::job_t                                   head_job,
    output logic                                             pop,
    output logic                                             idle,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] tap_raddr,
    input  logic [31:0]                                      tap_rdata,
    output logic [$clog2(RING_DEPTH)-1:0]                    ring_raddr,
    input  logic [31:0]                                      ring_rdata,
    output logic                                             res_valid,
    input  logic                                             res_stall,
    output fcme_pkg::res_item_t                              res_data
);
    import fcme_pkg::*;

    localparam int TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TCW = $clog2(MAX_TAPS + 1);
    localparam int RW  = $clog2(RING_DEPTH);
    localparam int MW  = TCW + RW + 1;

    back_state_t        state_reg;
    back_state_t        state_next;
    job_t               job_reg;
    logic signed [33:0] t_reg;
    logic signed [33:0] nm1_reg;
    logic [TCW-1:0]     d_reg;
    logic [RW-1:0]      ptr_reg;
    logic [TCW-1:0]     k_reg;
    logic               rd_v_reg;
    logic signed [63:0] prod_reg;
    logic               prod_v_reg;
    logic signed [63:0] acc_reg;
    logic [31:0]        res_reg;
    logic               out_valid_reg;
    res_item_t          out_data_reg;

    logic [TCW-1:0]     ntaps;
    logic [TCW-1:0]     half;
    logic [RW-1:0]      lp;
    logic signed [33:0] t_start;
    logic signed [33:0] nm1;
    logic signed [33:0] i_start;
    logic signed [33:0] d_start;
    logic [MW-1:0]      rem_w;
    logic [RW-1:0]      rem_r;
    logic [RW-1:0]      ptr_start;
    logic               issue;
    logic               step_down;
    logic [RW-1:0]      ptr_step;
    logic signed [63:0] sum;
    logic signed [63:0] acc_sat;
    logic signed [34:0] q_round;
    logic [31:0]        q_sat;
    logic               out_load;

    assign ntaps    = job_reg.ntaps[TCW-1:0];
    assign half     = ntaps >> 1;
    assign lp       = job_reg.last_ptr[RW-1:0];
    assign idle     = (state_reg == BK_IDLE);
    assign issue    = (state_reg == BK_MAC) && (k_reg < ntaps);
    assign out_load = (state_reg == BK_DONE) && (!out_valid_reg || !res_stall);

    // First position of the window, mirrored into the signal, and its
    // distance back from the newest sample.
    assign t_start = $signed({2'b00, job_reg.pos}) - $signed(34'(half));
    assign nm1     = $signed({2'b00, job_reg.count}) - 34'sd1;
    assign i_start = t_start[33] ? -t_start : t_start;
    assign d_start = nm1 - i_start;

    // Reduce the distance modulo the ring depth, one binary digit a step.
    always_comb
    begin
        rem_w = MW'(d_reg);
        for (int s = TCW - 1; s >= 0; s--)
        begin
            if (rem_w >= (MW'(RING_DEPTH) << s))
            begin
                rem_w = rem_w - (MW'(RING_DEPTH) << s);
            end
        end
        rem_r = rem_w[RW-1:0];
        if (lp >= rem_r)
        begin
            ptr_start = lp - rem_r;
        end
        else
        begin
            ptr_start = RW'({1'b0, lp} + (RW + 1)'(RING_DEPTH) - {1'b0, rem_r});
        end
    end

    // The mirrored index runs down left of the signal, up inside it and down
    // again once it passes the newest sample.
    assign step_down = t_reg[33] || !(t_reg < nm1_reg);
    always_comb
    begin
        if (step_down)
        begin
            ptr_step = (ptr_reg == '0) ? RW'(RING_DEPTH - 1) : ptr_reg - 1'b1;
        end
        else
        begin
            ptr_step = (ptr_reg == RW'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
        end
    end

    assign tap_raddr  = k_reg[TAW-1:0];
    assign ring_raddr = ptr_reg;

    // Saturating accumulate and round-half-up scaling by 2^-30.
    assign sum = acc_reg + prod_reg;
    always_comb
    begin
        acc_sat = sum;
        if ((acc_reg[63] == prod_reg[63]) && (sum[63] != acc_reg[63]))
        begin
            acc_sat = prod_reg[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        q_round = $signed({acc_reg[63], acc_reg[63:30]}) + $signed({34'd0, acc_reg[29]});
        if ((q_round[34:31] == 4'b0000) || (q_round[34:31] == 4'b1111))
        begin
            q_sat = q_round[31:0];
        end
        else
        begin
            q_sat = q_round[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_comb
    begin
        pop = 1'b0;
        case (state_reg)
            BK_IDLE: pop = !q_empty;
            default: pop = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                if (job_reg.short_flag || (ntaps == '0))
                begin
                    state_next = BK_SCALE;
                end
                else
                begin
                    state_next = BK_ADDR;
                end
            end
            BK_ADDR:  state_next = BK_MAC;
            BK_MAC:
            begin
                if (!(k_reg < ntaps))
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE: state_next = BK_DONE;
            BK_DONE:
            begin
                if (out_load)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_sat;
        end
        if (state_reg == BK_LOAD)
        begin
            t_reg   <= t_start;
            nm1_reg <= nm1;
            d_reg   <= d_start[TCW-1:0];
        end
        if (state_reg == BK_ADDR)
        begin
            ptr_reg <= ptr_start;
            k_reg   <= '0;
        end
        else if (issue)
        begin
            ptr_reg <= ptr_step;
            t_reg   <= t_reg + 34'sd1;
            k_reg   <= k_reg + 1'b1;
        end
        if (rd_v_reg)
        begin
            prod_reg <= $signed(tap_rdata) * $signed(ring_rdata);
        end
        if (state_reg == BK_SCALE)
        begin
            res_reg <= q_sat;
        end
        if (out_load)
        begin
            out_data_reg.result       <= res_reg;
            out_data_reg.last_res     <= job_reg.last_flag;
            out_data_reg.short_signal <= job_reg.short_flag;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

`ifndef SYNTHESIS
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCALE) |-> (!rd_v_reg && !prod_v_reg))
        else $error("scaling started with products still in flight");
    a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> ((state_reg == BK_MAC) || (state_reg == BK_DRAIN)))
        else $error("store read outside the kernel walk");
`endif

endmodule

[rtl/fir_convolve_mirror_edges.sv]
// ----------------------------------------------------------------------------
// fir_convolve_mirror_edges
// Streaming same-length FIR convolution with mirrored signal edges.
// ----------------------------------------------------------------------------
// Load the kernel as tap items (the tap marked last ends it), then stream
// sample items; output j appears once sample j+half has arrived, and the last
// sample flushes the rest, flagged short_signal when the signal had no more
// samples than half the kernel. A sample item is stored as it is taken, and
// each output it causes is computed by the single multiply-accumulate, which
// walks one tap a cycle through the read ports of the tap and sample memories
// (a short signal or an empty kernel skips the walk); a new item is taken
// only after every earlier output has left the accumulator. A flush queues up
// to half + 1 outputs, so the last sample of a signal holds the input until
// all of them have left the accumulator.
module fir_convolve_mirror_edges #(
    parameter int MAX_TAPS   = fcme_pkg::MAX_TAPS_DEFAULT,
    parameter int RING_DEPTH = fcme_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  fcme_pkg::req_item_t req_data,
    output logic                res_valid,
    input  logic                res_stall,
    output fcme_pkg::res_item_t res_data
);
    import fcme_pkg::*;

    localparam int TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int RW  = $clog2(RING_DEPTH);

    logic           back_idle;
    logic           q_empty;
    logic           q_full;
    logic           push;
    logic           pop;
    job_t           push_job;
    job_t           head_job;
    logic           tap_we;
    logic [TAW-1:0] tap_waddr;
    logic [31:0]    tap_wdata;
    logic [TAW-1:0] tap_raddr;
    logic [31:0]    tap_rdata;
    logic           ring_we;
    logic [RW-1:0]  ring_waddr;
    logic [31:0]    ring_wdata;
    logic [RW-1:0]  ring_raddr;
    logic [31:0]    ring_rdata;

    fcme_front #(
        .MAX_TAPS   (MAX_TAPS),
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .back_idle  (back_idle),
        .q_empty    (q_empty),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job),
        .tap_we     (tap_we),
        .tap_waddr  (tap_waddr),
        .tap_wdata  (tap_wdata),
        .ring_we    (ring_we),
        .ring_waddr (ring_waddr),
        .ring_wdata (ring_wdata)
    );

    fcme_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    fcme_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (tap_wdata),
        .raddr (tap_raddr),
        .rdata (tap_rdata)
    );

    fcme_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    fcme_back #(
        .MAX_TAPS   (MAX_TAPS),
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head_job   (head_job),
        .pop        (pop),
        .idle       (back_idle),
        .tap_raddr  (tap_raddr),
        .tap_rdata  (tap_rdata),
        .ring_raddr (ring_raddr),
        .ring_rdata (ring_rdata),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

`ifndef SYNTHESIS
    a_accept_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> (q_empty && back_idle))
        else $error("item taken while a computation was pending");
`endif

endmodule

[tb/fir_convolve_mirror_edges_tb.sv]
// ----------------------------------------------------------------------------
// fir_convolve_mirror_edges_tb
// Drives kernel taps and signal samples into the mirrored-edge FIR block,
// predicts every filtered sample with an independent model of the convolution
// and compares each result item in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module fir_convolve_mirror_edges_tb;
    import fcme_pkg::*;

    localparam int NTAPS_MAX = MAX_TAPS_DEFAULT;
    localparam int RING_SZ   = RING_DEPTH_DEFAULT;
    localparam int IDLE_LIMIT = 5000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req_data;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_data;

    fir_convolve_mirror_edges u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data (req_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data (res_data)
    );

    // Predictor state.
    logic signed [31:0] kern_taps [NTAPS_MAX];
    logic signed [31:0] sig_ring [RING_SZ];
    int unsigned        kern_len;
    int unsigned        sig_len;
    int unsigned        sig_emitted;
    bit                 kern_closed;

    res_item_t filtered_q[$];
    int        n_errors;
    int        n_items;
    bit        no_idle;
    int        idle_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (a > 0 && b > 0 && s < 0)
            return 64'sh7FFFFFFFFFFFFFFF;
        if (a < 0 && b < 0 && s >= 0)
            return 64'sh8000000000000000;
        return s;
    endfunction

    function automatic logic signed [31:0] filter_at(longint j, longint n);
        longint half;
        longint acc;
        longint i;
        longint q;
        longint frac;
        half = kern_len / 2;
        acc  = 0;
        for (int k = 0; k < kern_len; k++)
        begin
            i = j + k - half;
            if (i < 0)
                i = -i;
            if (i >= n)
                i = 2 * n - 2 - i;
            if (i < 0)
                i = 0;
            acc = sat_sum(acc, longint'(sig_ring[i % RING_SZ]) * longint'(kern_taps[k]));
        end
        // Round to nearest, ties toward plus infinity, then clamp to 32 bits.
        q    = acc >>> 30;
        frac = acc & 64'h3FFFFFFF;
        if (frac >= 64'h20000000)
            q = q + 1;
        if (q > 64'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (q < -64'sh80000000)
            return 32'sh80000000;
        return q[31:0];
    endfunction

    task automatic expect_result(res_item_t r);
        filtered_q = {filtered_q, r};
    endtask

    task automatic predict_item(req_item_t it);
        res_item_t r;
        bit        fin;
        bit        shrt;
        int unsigned half;
        half = kern_len / 2;
        if (it.req_type == REQ_TAP)
        begin
            if (kern_closed)
            begin
                kern_len    = 0;
                kern_closed = 1'b0;
            end
            sig_len     = 0;
            sig_emitted = 0;
            if (kern_len < NTAPS_MAX)
            begin
                kern_taps[kern_len] = it.value;
                kern_len++;
            end
            if (it.last)
                kern_closed = 1'b1;
            return;
        end
        kern_closed = 1'b1;
        sig_ring[sig_len % RING_SZ] = it.value;
        sig_len++;
        fin = it.last || (sig_len == 32'hFFFFFFFF);
        if (fin)
        begin
            shrt = (sig_len <= half);
            for (longint j = sig_emitted; j < sig_len; j++)
            begin
                r.result       = shrt ? 32'sd0 : filter_at(j, sig_len);
                r.last_res     = (j == sig_len - 1);
                r.short_signal = shrt;
                expect_result(r);
            end
            sig_len     = 0;
            sig_emitted = 0;
        end
        else if (longint'(sig_emitted) + half < longint'(sig_len))
        begin
            r.result       = filter_at(sig_emitted, sig_len);
            r.last_res     = 1'b0;
            r.short_signal = 1'b0;
            expect_result(r);
            sig_emitted++;
        end
    endtask

    task automatic send_item(logic rt, logic signed [31:0] v, logic l);
        int gap;
        req_item_t it;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        it.req_type = rt;
        it.value    = v;
        it.last     = l;
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= it;
        do
            @(posedge clk);
        while (req_stall);
        predict_item(it);
        n_items++;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
            default: return $urandom;
        endcase
    endfunction

    // Result side: stall for a random count before each result item.
    initial
    begin
        int gap;
        res_stall = 1'b1;
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 13);
            repeat (gap)
            begin
                @(negedge clk);
                res_stall <= 1'b1;
            end
            @(negedge clk);
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(res_valid && !res_stall));
        end
    end

    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (filtered_q.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, res_data);
                n_errors++;
            end
            else
            begin
                want = filtered_q.pop_front();
                if (res_data.result !== want.result)
                begin
                    $display("%0t: result expected %h actual %h",
                             $time, want.result, res_data.result);
                    n_errors++;
                end
                if (res_data.last_res !== want.last_res)
                begin
                    $display("%0t: last_res expected %b actual %b",
                             $time, want.last_res, res_data.last_res);
                    n_errors++;
                end
                if (res_data.short_signal !== want.short_signal)
                begin
                    $display("%0t: short_signal expected %b actual %b",
                             $time, want.short_signal, res_data.short_signal);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("fir_convolve_mirror_edges_tb: done, errors");
            $finish;
        end
    end

    task automatic send_signal(int len);
        for (int i = 0; i < len; i++)
            send_item(REQ_SAMPLE, pick_value(), i == len - 1);
    endtask

    task automatic send_kernel(int len, bit closed);
        for (int i = 0; i < len; i++)
            send_item(REQ_TAP, pick_value(), closed && i == len - 1);
    endtask

    // Samples right after reset see an empty kernel.
    task automatic test_empty_kernel();
        send_item(REQ_SAMPLE, 32'sh7FFFFFFF, 1'b0);
        send_item(REQ_SAMPLE, 32'sh80000000, 1'b1);
    endtask

    // Extreme taps and samples, including accumulator saturation.
    task automatic test_extremes();
        send_item(REQ_TAP, 32'sh80000000, 1'b0);
        send_item(REQ_TAP, 32'sh80000000, 1'b0);
        send_item(REQ_TAP, 32'sh7FFFFFFF, 1'b1);
        send_item(REQ_SAMPLE, 32'sh80000000, 1'b0);
        send_item(REQ_SAMPLE, 32'sh80000000, 1'b0);
        send_item(REQ_SAMPLE, 32'sh7FFFFFFF, 1'b0);
        send_item(REQ_SAMPLE, 32'sh00000000, 1'b0);
        send_item(REQ_SAMPLE, 32'shFFFFFFFF, 1'b1);
    endtask

    task automatic test_kernel_cases();
        // A sample ends an open kernel; then a tap during the signal abandons it.
        send_item(REQ_TAP, 32'sh40000000, 1'b0);
        send_item(REQ_TAP, 32'shC0000000, 1'b0);
        send_item(REQ_TAP, 32'sh20000000, 1'b0);
        send_item(REQ_SAMPLE, 32'sh00010000, 1'b0);
        send_item(REQ_SAMPLE, 32'sh00028000, 1'b0);
        send_item(REQ_TAP, 32'sh10000000, 1'b0);
        send_item(REQ_TAP, 32'sh30000000, 1'b0);
        send_item(REQ_TAP, 32'sh50000000, 1'b0);
        send_item(REQ_TAP, 32'sh70000000, 1'b0);
        send_item(REQ_TAP, 32'shF0000000, 1'b1);
        // Signal no longer than half the kernel, then a single-sample signal.
        send_item(REQ_SAMPLE, 32'sh00030000, 1'b0);
        send_item(REQ_SAMPLE, 32'sh00040000, 1'b1);
        send_item(REQ_SAMPLE, 32'sh00050000, 1'b1);
        send_signal(6);
    endtask

    // Taps beyond the store size are dropped; a signal just longer than half
    // of the full kernel shows whether the dropped tap was counted.
    task automatic test_tap_overflow();
        send_kernel(64, 1'b1);
        send_signal(32);
    endtask

    task automatic test_random();
        int slen;
        while (n_items < 130)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            send_kernel($urandom_range(1, 9), $urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 2))
            begin
                slen = $urandom_range(1, 10);
                if ($urandom_range(0, 7) == 0)
                begin
                    // Broken signal: cut short by a tap load.
                    for (int i = 0; i < slen; i++)
                        send_item(REQ_SAMPLE, pick_value(), 1'b0);
                    break;
                end
                send_signal(slen);
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        n_errors    = 0;
        n_items     = 0;
        no_idle     = 1'b0;
        idle_cycles = 0;
        kern_len    = 0;
        sig_len     = 0;
        sig_emitted = 0;
        kern_closed = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_kernel();
        test_extremes();
        test_kernel_cases();
        test_tap_overflow();
        test_random();

        @(negedge clk);
        req_valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (n_errors == 0 && filtered_q.size() == 0)
            $display("fir_convolve_mirror_edges_tb: done, clean");
        else
            $display("fir_convolve_mirror_edges_tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/fcme_pkg.sv
rtl/fcme_ram.sv
rtl/fcme_queue.sv
rtl/fcme_front.sv
rtl/fcme_back.sv
rtl/fir_convolve_mirror_edges.sv
tb/fir_convolve_mirror_edges_tb.sv
